[design/conv3x3_sharpen_emboss_assert.svh]
// conv3x3_sharpen_emboss_assert.svh: assertion macros for the 3x3 filter checker.
// No dependencies; included by the checker file.
`ifndef CONV3X3_SHARPEN_EMBOSS_ASSERT_SVH
`define CONV3X3_SHARPEN_EMBOSS_ASSERT_SVH

// same-cycle implication
`define C3SE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3se assertion failed");

// next-cycle implication
`define C3SE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3se assertion failed");

`endif

[design/c3se_pkg.sv]
`timescale 1ns / 1ps
// c3se_pkg: types, constants and register codes of the 3x3 BGR filter.
// No dependencies.
package c3se_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int COEF_FRAC_BITS = 8;

    localparam int PIX_W   = 24;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int DIM_W   = 12;
    localparam int CNT_W   = DIM_W + 1;
    localparam int CW_W    = 16;
    localparam int BIAS_W  = 9;
    localparam int ACC_W   = CW_W + 9;
    localparam int EMB_W   = 12;
    localparam int APB_AW  = 5;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_FILTER_MODE   = 3'd2,
        REG_CENTER_WEIGHT = 3'd3,
        REG_EMBOSS_BIAS   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic       flush;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       frame_end;
    } pixel_out_t;

    typedef struct packed {
        logic                     filter_mode;
        logic signed [CW_W-1:0]   center_weight;
        logic signed [BIAS_W-1:0] emboss_bias;
    } filt_cfg_t;

    // one neighborhood ready for the arithmetic; word = {red, green, blue}
    typedef struct packed {
        logic                       frame_end;
        logic [8:0]                 ok;
        logic [8:0][PIX_W-1:0]      win;
    } kern_req_t;

    typedef struct packed {
        logic       valid;
        pixel_out_t pix;
    } kern_res_t;

endpackage

[design/c3se_kernel.sv]
`timescale 1ns / 1ps
// c3se_kernel: two-stage per-channel sharpen/emboss arithmetic with rounding and clamp.
// Depends on c3se_pkg.
module c3se_kernel
    import c3se_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  kern_req_t req,
    input  filt_cfg_t cfg,
    output kern_res_t res
);

    logic [2:0][8:0][7:0]     tap;
    logic [2:0][10:0]         pos_sum;
    logic [2:0][9:0]          neg_sum;
    logic [2:0][9:0]          ring_sum;
    logic signed [EMB_W-1:0]  emb_sum  [3];
    logic signed [ACC_W-1:0]  prod     [3];
    logic signed [ACC_W-1:0]  sharp    [3];
    logic signed [ACC_W-1:0]  acc_next [3];

    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic                     d_valid_reg;
    logic                     d_fe_reg;

    logic [EMB_W-1:0]         emb_d    [3];
    logic [7:0]               emb_clip [3];
    logic [9:0]               biased   [3];
    logic [ACC_W-1:0]         rnd      [3];
    logic [ACC_W-COEF_FRAC_BITS-1:0] qv [3];
    logic [7:0]               chan_out [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                tap[ch][i] = req.ok[i] ? req.win[i][8*ch +: 8] : 8'd0;
            end
            pos_sum[ch]  = 11'(tap[ch][4]) + 11'(tap[ch][5]) + 11'(tap[ch][7])
                         + {2'b00, tap[ch][8], 1'b0};
            neg_sum[ch]  = {1'b0, tap[ch][0], 1'b0} + 10'(tap[ch][1]) + 10'(tap[ch][3]);
            emb_sum[ch]  = $signed({1'b0, pos_sum[ch]}) - $signed({2'b00, neg_sum[ch]});
            ring_sum[ch] = 10'(tap[ch][1]) + 10'(tap[ch][3]) + 10'(tap[ch][5])
                         + 10'(tap[ch][7]);
            prod[ch]     = $signed(cfg.center_weight) * $signed({1'b0, tap[ch][4]});
            sharp[ch]    = prod[ch] - $signed({{(ACC_W-10-COEF_FRAC_BITS){1'b0}},
                                               ring_sum[ch], {COEF_FRAC_BITS{1'b0}}});
            acc_next[ch] = cfg.filter_mode
                         ? $signed({{(ACC_W-EMB_W){emb_sum[ch][EMB_W-1]}}, emb_sum[ch]})
                         : sharp[ch];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_fe_reg <= req.frame_end;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            // emboss: clamp, add bias, clamp again
            emb_d[ch] = acc_reg[ch][EMB_W-1:0];
            if (emb_d[ch][EMB_W-1])
                emb_clip[ch] = 8'd0;
            else if (|emb_d[ch][EMB_W-2:8])
                emb_clip[ch] = 8'd255;
            else
                emb_clip[ch] = emb_d[ch][7:0];
            biased[ch] = {2'b00, emb_clip[ch]}
                       + {cfg.emboss_bias[BIAS_W-1], cfg.emboss_bias};

            // sharpen: round half up, clamp
            rnd[ch] = $unsigned(acc_reg[ch]) + ACC_W'(1 << (COEF_FRAC_BITS - 1));
            qv[ch]  = rnd[ch][ACC_W-1:COEF_FRAC_BITS];

            if (cfg.filter_mode)
            begin
                if (biased[ch][9])
                    chan_out[ch] = 8'd0;
                else if (biased[ch][8])
                    chan_out[ch] = 8'd255;
                else
                    chan_out[ch] = biased[ch][7:0];
            end
            else
            begin
                if (acc_reg[ch][ACC_W-1] || (acc_reg[ch] == '0))
                    chan_out[ch] = 8'd0;
                else if (|qv[ch][ACC_W-COEF_FRAC_BITS-1:8])
                    chan_out[ch] = 8'd255;
                else
                    chan_out[ch] = qv[ch][7:0];
            end
        end
    end

    assign res.valid         = d_valid_reg;
    assign res.pix.blue_out  = chan_out[0];
    assign res.pix.green_out = chan_out[1];
    assign res.pix.red_out   = chan_out[2];
    assign res.pix.frame_end = d_fe_reg;

endmodule

[design/c3se_out_fifo.sv]
`timescale 1ns / 1ps
// c3se_out_fifo: result queue between the filter pipeline and the output channel.
// Depends on c3se_pkg.
module c3se_out_fifo
    import c3se_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  kern_res_t          push,
    output logic               res_valid,
    input  logic               res_ready,
    output pixel_out_t         res_data,
    output logic [FIFO_CW-1:0] count
);

    pixel_out_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg;
    logic [FIFO_AW-1:0]  rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg;
    logic [FIFO_AW-1:0]  wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_next;
    logic [FIFO_CW-1:0]  count_next;
    logic                pop;

    assign res_valid = (count_reg != '0);
    assign res_data  = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = res_valid && res_ready;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push.valid) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            fifo_mem[wr_ptr_reg] <= push.pix;
        end
    end

endmodule

[design/conv3x3_sharpen_emboss.sv]
`timescale 1ns / 1ps
// conv3x3_sharpen_emboss: streaming 3x3 sharpen/emboss filter on BGR pixels, top level.
// Depends on c3se_pkg, c3se_kernel, c3se_out_fifo.
//
// Pixels enter in raster order, one transaction per clock while pix_ready holds; the rate is set by
// the one-read one-write line memory (2048 x 48 bits), read in the accept cycle and written
// back in the following cycle, with the previous write forwarded when both hit the same column.
// The result of pixel n of a frame leaves with input transaction n + W + 1 (W the width);
// drain the frame with W + 1 flush transactions. Flushes while pixels are still expected
// are taken and dropped. res_valid rises once the accepted transaction has passed the line
// memory stage registers, the arithmetic request register, the kernel accumulator and the
// write into the output queue. An 8-deep output queue absorbs stalls; pix_ready drops only when
// the queue plus the results in flight would fill it. The line memory is not cleared at reset
// and needs no clearing pass. Write configuration only between frames with the block idle.
module conv3x3_sharpen_emboss
    import c3se_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              pix_valid,
    output logic              pix_ready,
    input  pixel_in_t         pix_data,

    output logic              res_valid,
    input  logic              res_ready,
    output pixel_out_t        res_data
);

    // configuration
    logic [DIM_W-1:0]         image_width_reg;
    logic [DIM_W-1:0]         image_height_reg;
    logic                     filter_mode_reg;
    logic signed [CW_W-1:0]   center_weight_reg;
    logic signed [BIAS_W-1:0] emboss_bias_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;
    filt_cfg_t                filt_cfg;

    logic [DIM_W-1:0]         w_eff;
    logic [DIM_W-1:0]         h_eff;
    logic [CNT_W-1:0]         w_x;
    logic [CNT_W-1:0]         h_x;

    // position counters
    logic [COL_W-1:0]         icol_reg, icol_next;
    logic [CNT_W-1:0]         irow_reg, irow_next;
    logic [COL_W-1:0]         ocol_reg, ocol_next;
    logic [DIM_W-1:0]         orow_reg, orow_next;
    logic [CNT_W-1:0]         icol_inc, ocol_inc, orow_inc;

    // accept stage
    logic                     accept;
    logic                     taking;
    logic                     step;
    logic                     emit;
    logic                     frame_last;
    logic [2:0]               rok;
    logic [2:0]               cok;
    logic [8:0]               ok_a;
    logic [PIX_W-1:0]         px_a;
    logic [FIFO_CW-1:0]       fifo_cnt;
    logic [FIFO_CW:0]         occupancy;

    // line memory stage
    logic [2*PIX_W-1:0]       line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]       line_rd_reg;
    logic                     b_valid_reg;
    logic                     b_emit_reg;
    logic                     b_fe_reg;
    logic                     b_zero_reg;
    logic                     b_shift2_reg;
    logic [8:0]               b_ok_reg;
    logic [PIX_W-1:0]         b_px_reg;
    logic [COL_W-1:0]         b_addr_reg;
    logic                     fwd_valid_reg;
    logic [COL_W-1:0]         fwd_addr_reg;
    logic [2*PIX_W-1:0]       fwd_data_reg;
    logic [2*PIX_W-1:0]       rd_word;
    logic [2*PIX_W-1:0]       wr_word;
    logic [2:0][PIX_W-1:0]    col_b;

    // window
    logic [8:0][PIX_W-1:0]    window_reg;
    logic [8:0][PIX_W-1:0]    win_mid;
    logic [8:0][PIX_W-1:0]    win_next;

    // arithmetic
    logic                     c_valid_reg;
    kern_req_t                c_req_reg;
    kern_res_t                kern_res;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= DIM_W'(640);
            image_height_reg  <= DIM_W'(480);
            filter_mode_reg   <= 1'b0;
            center_weight_reg <= CW_W'(1280);
            emboss_bias_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[DIM_W-1:0];
                REG_FILTER_MODE:   filter_mode_reg   <= pwdata[0];
                REG_CENTER_WEIGHT: center_weight_reg <= pwdata[CW_W-1:0];
                REG_EMBOSS_BIAS:   emboss_bias_reg   <= pwdata[BIAS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:   prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = 32'(image_height_reg);
            REG_FILTER_MODE:   prdata = 32'(filter_mode_reg);
            REG_CENTER_WEIGHT: prdata = 32'($unsigned(center_weight_reg));
            REG_EMBOSS_BIAS:   prdata = 32'($unsigned(emboss_bias_reg));
            default:           prdata = '0;
        endcase
    end

    assign filt_cfg.filter_mode   = filter_mode_reg;
    assign filt_cfg.center_weight = center_weight_reg;
    assign filt_cfg.emboss_bias   = emboss_bias_reg;

    // zero acts as one; width saturates to the line memory depth
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (image_width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = image_width_reg;
        h_eff = (image_height_reg == '0) ? DIM_W'(1) : image_height_reg;
    end

    assign w_x = CNT_W'(w_eff);
    assign h_x = CNT_W'(h_eff);

    // ---------------- accept stage ----------------
    assign occupancy = (FIFO_CW+1)'(fifo_cnt) + (FIFO_CW+1)'(b_valid_reg && b_emit_reg)
                     + (FIFO_CW+1)'(c_valid_reg) + (FIFO_CW+1)'(kern_res.valid);
    assign pix_ready = occupancy < (FIFO_CW+1)'(FIFO_DEPTH);
    assign accept    = pix_valid && pix_ready;

    assign taking = irow_reg < h_x;
    assign step   = accept && !(pix_data.flush && taking);
    assign px_a   = taking ? {pix_data.red_in, pix_data.green_in, pix_data.blue_in} : '0;

    assign icol_inc = CNT_W'(icol_reg) + CNT_W'(1);
    assign ocol_inc = CNT_W'(ocol_reg) + CNT_W'(1);
    assign orow_inc = CNT_W'(orow_reg) + CNT_W'(1);

    assign emit       = (irow_reg >= CNT_W'(2)) || (irow_reg == CNT_W'(1) && icol_reg != '0);
    assign frame_last = (orow_inc >= h_x) && (ocol_inc >= w_x);

    assign rok[0] = orow_reg != '0;
    assign rok[1] = CNT_W'(orow_reg) < h_x;
    assign rok[2] = orow_inc < h_x;
    assign cok[0] = ocol_reg != '0;
    assign cok[1] = CNT_W'(ocol_reg) < w_x;
    assign cok[2] = ocol_inc < w_x;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ok_a[r*3 + c] = rok[r] && cok[c];
            end
        end
    end

    always_comb
    begin
        icol_next = icol_reg;
        irow_next = irow_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (step)
        begin
            if (emit && frame_last)
            begin
                icol_next = '0;
                irow_next = '0;
                ocol_next = '0;
                orow_next = '0;
            end
            else
            begin
                if (emit)
                begin
                    if (ocol_inc >= w_x)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + DIM_W'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_inc[COL_W-1:0];
                    end
                end
                if (icol_inc >= w_x)
                begin
                    icol_next = '0;
                    irow_next = irow_reg + CNT_W'(1);
                end
                else
                begin
                    icol_next = icol_inc[COL_W-1:0];
                end
            end
        end
    end

    // ---------------- line memory ----------------
    always_ff @(posedge clk)
    begin
        line_rd_reg <= line_mem[icol_reg];
        if (b_valid_reg)
        begin
            line_mem[b_addr_reg] <= wr_word;
        end
    end

    // previous write lands on the edge this read was issued
    assign rd_word  = (fwd_valid_reg && fwd_addr_reg == b_addr_reg) ? fwd_data_reg : line_rd_reg;
    assign col_b[0] = rd_word[2*PIX_W-1:PIX_W];
    assign col_b[1] = rd_word[PIX_W-1:0];
    assign col_b[2] = b_px_reg;
    assign wr_word  = {rd_word[PIX_W-1:0], b_px_reg};

    // ---------------- window ----------------
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_mid[r*3 + 0] = window_reg[r*3 + 1];
            win_mid[r*3 + 1] = window_reg[r*3 + 2];
            win_mid[r*3 + 2] = b_zero_reg ? '0 : col_b[r];
            if (b_shift2_reg)
            begin
                win_next[r*3 + 0] = win_mid[r*3 + 1];
                win_next[r*3 + 1] = win_mid[r*3 + 2];
                win_next[r*3 + 2] = col_b[r];
            end
            else
            begin
                win_next[r*3 + 0] = win_mid[r*3 + 0];
                win_next[r*3 + 1] = win_mid[r*3 + 1];
                win_next[r*3 + 2] = win_mid[r*3 + 2];
            end
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icol_reg      <= '0;
            irow_reg      <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            c_valid_reg   <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            icol_reg      <= icol_next;
            irow_reg      <= irow_next;
            ocol_reg      <= ocol_next;
            orow_reg      <= orow_next;
            b_valid_reg   <= step;
            fwd_valid_reg <= b_valid_reg;
            c_valid_reg   <= b_valid_reg && b_emit_reg;
            if (b_valid_reg)
            begin
                window_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_emit_reg   <= emit;
        b_fe_reg     <= frame_last;
        b_zero_reg   <= (icol_reg == '0);
        b_shift2_reg <= (icol_reg == '0) && !(emit && frame_last);
        b_ok_reg     <= ok_a;
        b_px_reg     <= px_a;
        b_addr_reg   <= icol_reg;
        fwd_addr_reg <= b_addr_reg;
        fwd_data_reg <= wr_word;
        c_req_reg.frame_end <= b_fe_reg;
        c_req_reg.ok        <= b_ok_reg;
        c_req_reg.win       <= win_mid;
    end

    // ---------------- arithmetic and output ----------------
    c3se_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (c_valid_reg),
        .req       (c_req_reg),
        .cfg       (filt_cfg),
        .res       (kern_res)
    );

    c3se_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (kern_res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .count     (fifo_cnt)
    );

endmodule

[design/c3se_checker.sv]
`timescale 1ns / 1ps
// c3se_checker: port-level assertions for the 3x3 filter, bound to the top level.
// Depends on c3se_pkg and conv3x3_sharpen_emboss_assert.svh.
`include "conv3x3_sharpen_emboss_assert.svh"

module c3se_checker
    import c3se_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready,
    input logic              pix_valid,
    input logic              pix_ready,
    input logic              res_valid,
    input logic              res_ready,
    input pixel_out_t        res_data
);

    logic mode_wr;
    logic mode_rd;

    assign mode_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_FILTER_MODE);
    assign mode_rd = psel && !pwrite && (paddr[APB_AW-1:2] == REG_FILTER_MODE);

    `C3SE_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, pready)
    `C3SE_ASSERT_NXT(a_mode_readback, clk, rst_n, mode_wr, !mode_rd || prdata[0] == $past(pwdata[0]))
    `C3SE_ASSERT_IMP(a_result_latency, clk, rst_n, $rose(res_valid), $past(pix_valid && pix_ready, 4))
    `C3SE_ASSERT_NXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data))

endmodule

bind conv3x3_sharpen_emboss c3se_checker u_checker (.*);
